// ===== sv/jse_pkg.sv =====
// Shared types and constants for the JSON string escaper.
// No dependencies; imported by the encoder, the byte emitter and the top level.
package jse_pkg;

   localparam int MaxBytes = 12;   // longest byte burst for one code unit
   localparam int CntW     = 4;    // holds 0..MaxBytes

   typedef logic [7:0] octet_type;

   // Characters used by the escapes
   localparam octet_type CharBslash = 8'h5c;
   localparam octet_type CharQuote  = 8'h22;
   localparam octet_type CharU      = 8'h75;
   localparam octet_type CharZero   = 8'h30;
   localparam octet_type CharB      = 8'h62;
   localparam octet_type CharF      = 8'h66;
   localparam octet_type CharN      = 8'h6e;
   localparam octet_type CharR      = 8'h72;
   localparam octet_type CharT      = 8'h74;

   // Control codes with short escapes
   localparam octet_type CtlBs = 8'h08;
   localparam octet_type CtlFf = 8'h0c;
   localparam octet_type CtlLf = 8'h0a;
   localparam octet_type CtlCr = 8'h0d;
   localparam octet_type CtlHt = 8'h09;

   // Bytes for one input transaction, first byte in data[0]
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] data;
      logic [CntW-1:0]          count;
   } burst_type;

   // Emitter status toward the top level
   typedef struct packed {
      logic can_load;   // a new burst may be loaded this cycle
      logic busy;       // bytes still pending
   } emit_status_type;

endpackage

// ===== sv/json_string_escape_utf8_unit.sv =====
// JSON string body escaper: one UTF-16 code unit per req transaction in, the escaped
// UTF-8 bytes out, one byte per rsp transaction, rsp_tlast on the final byte of a unit.
// Depends on jse_pkg, jse_encode and jse_emit.
//
// A unit is registered on input, encoded combinationally into a burst of 0 to 12 bytes,
// and loaded into the result register, which then sends one byte per cycle while
// rsp_tready is high. A unit's burst holds 1 byte for ASCII, 2 to 4 for UTF-8, 2 or 6
// for escapes, and up to 12 when a held high surrogate is flushed as \uXXXX ahead of
// the next unit. The next unit is accepted in the same cycle the last byte of the
// current burst is taken, so plain ASCII streams at one unit per cycle while rsp_tready
// is high. A high surrogate that is not marked last produces no bytes: it is held until
// the next unit, which either pairs with it (one 4-byte sequence) or forces it out as a
// lowercase \uXXXX escape. Lone low surrogates and a high surrogate on the last unit are
// escaped the same way. Quotes around the string are not generated.
module json_string_escape_utf8_unit
   import jse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] code_unit
   input  logic        req_tlast,    // last_unit
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast     // run_end
);

   // Input register
   logic            in_valid_ff, in_valid_in;
   logic [15:0]     in_unit_ff, in_unit_in;
   logic            in_last_ff, in_last_in;

   // Pending high surrogate
   logic            held_valid_ff, held_valid_in;
   logic [15:0]     held_high_ff, held_high_in;

   burst_type       burst;
   logic            hold_next;
   emit_status_type emit_status;
   logic            move;      // input register hands its unit to the result register
   logic            req_take;

   assign move       = in_valid_ff && emit_status.can_load;
   assign req_tready = !in_valid_ff || emit_status.can_load;
   assign req_take   = req_tvalid && req_tready;

   jse_encode u_encode (
      .held_valid (held_valid_ff),
      .held_high  (held_high_ff),
      .code_unit  (in_unit_ff),
      .last_unit  (in_last_ff),
      .burst      (burst),
      .hold_next  (hold_next)
   );

   jse_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (move),
      .burst      (burst),
      .status     (emit_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_unit_in  = in_unit_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_unit_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   // Hold state advances only when a unit is consumed by the encoder
   always_comb begin
      held_valid_in = held_valid_ff;
      held_high_in  = held_high_ff;
      if (move) begin
         held_valid_in = hold_next;
         held_high_in  = hold_next ? in_unit_ff : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         held_high_ff  <= 16'h0000;
      end else begin
         in_valid_ff   <= in_valid_in;
         held_valid_ff <= held_valid_in;
         held_high_ff  <= held_high_in;
      end
      in_unit_ff <= in_unit_in;
      in_last_ff <= in_last_in;
   end

   // Only a high surrogate is ever held
   a_held_is_high: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (held_high_ff[15:10] == 6'b110110))
      else $error("held unit is not a high surrogate");

   // The last unit of a string never leaves anything held
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (move && in_last_ff) |=> !held_valid_ff)
      else $error("surrogate still held after last unit");

   // A pending unit is never overwritten before the encoder consumes it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_take && in_valid_ff) |-> move)
      else $error("input register overwritten");

   // Bytes are only presented while the emitter reports busy
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> emit_status.busy)
      else $error("result valid without pending burst");

endmodule

// ===== sv/jse_encode.sv =====
// Combinational encoder: one UTF-16 code unit plus held high surrogate to a byte burst.
// Depends on jse_pkg.
module jse_encode
   import jse_pkg::*;
(
   input  logic        held_valid,
   input  logic [15:0] held_high,
   input  logic [15:0] code_unit,
   input  logic        last_unit,
   output burst_type   burst,
   output logic        hold_next
);

   function automatic octet_type hex_digit(input logic [3:0] v);
      hex_digit = (v < 4'd10) ? (8'h30 + {4'b0, v}) : (8'h57 + {4'b0, v});
   endfunction

   function automatic logic [5:0][7:0] u_escape(input logic [15:0] u);
      logic [5:0][7:0] e;
      e[0] = CharBslash;
      e[1] = CharU;
      e[2] = hex_digit(u[15:12]);
      e[3] = hex_digit(u[11:8]);
      e[4] = hex_digit(u[7:4]);
      e[5] = hex_digit(u[3:0]);
      u_escape = e;
   endfunction

   logic            is_high;
   logic            is_low;
   logic [5:0][7:0] ub;
   logic [2:0]      ucnt;
   logic [20:0]     cp;

   assign is_high   = (code_unit[15:10] == 6'b110110);
   assign is_low    = (code_unit[15:10] == 6'b110111);
   assign hold_next = is_high && !last_unit;
   assign cp        = {1'b0, held_high[9:0], code_unit[9:0]} + 21'h10000;

   // Bytes for the unit on its own
   always_comb begin
      ub   = '0;
      ucnt = 3'd0;
      if (code_unit < 16'h0080) begin
         if (code_unit < 16'h0020 || code_unit[7:0] == CharQuote ||
             code_unit[7:0] == CharBslash) begin
            ub[0] = CharBslash;
            ucnt  = 3'd2;
            case (code_unit[7:0])
               CharQuote:  ub[1] = CharQuote;
               CharBslash: ub[1] = CharBslash;
               CtlBs:      ub[1] = CharB;
               CtlFf:      ub[1] = CharF;
               CtlLf:      ub[1] = CharN;
               CtlCr:      ub[1] = CharR;
               CtlHt:      ub[1] = CharT;
               default: begin
                  ub[1] = CharU;
                  ub[2] = CharZero;
                  ub[3] = CharZero;
                  ub[4] = hex_digit(code_unit[7:4]);
                  ub[5] = hex_digit(code_unit[3:0]);
                  ucnt  = 3'd6;
               end
            endcase
         end else begin
            ub[0] = code_unit[7:0];
            ucnt  = 3'd1;
         end
      end else if (code_unit < 16'h0800) begin
         ub[0] = 8'hc0 | {3'b0, code_unit[10:6]};
         ub[1] = 8'h80 | {2'b0, code_unit[5:0]};
         ucnt  = 3'd2;
      end else if (!is_high && !is_low) begin
         ub[0] = 8'he0 | {4'b0, code_unit[15:12]};
         ub[1] = 8'h80 | {2'b0, code_unit[11:6]};
         ub[2] = 8'h80 | {2'b0, code_unit[5:0]};
         ucnt  = 3'd3;
      end else if (is_high && !last_unit) begin
         ucnt = 3'd0;   // held, nothing yet
      end else begin
         ub   = u_escape(code_unit);
         ucnt = 3'd6;
      end
   end

   // Merge with a pending high surrogate
   always_comb begin
      burst.data  = '0;
      burst.count = '0;
      if (held_valid && is_low) begin
         burst.data[0] = 8'hf0 | {5'b0, cp[20:18]};
         burst.data[1] = 8'h80 | {2'b0, cp[17:12]};
         burst.data[2] = 8'h80 | {2'b0, cp[11:6]};
         burst.data[3] = 8'h80 | {2'b0, cp[5:0]};
         burst.count   = CntW'(4);
      end else if (held_valid) begin
         burst.data[5:0]  = u_escape(held_high);
         burst.data[11:6] = ub;
         burst.count      = CntW'(6) + CntW'(ucnt);
      end else begin
         burst.data[5:0] = ub;
         burst.count     = CntW'(ucnt);
      end
   end

endmodule

// ===== sv/jse_emit.sv =====
// Result register and byte serializer: sends a loaded burst one byte per transaction.
// Depends on jse_pkg.
module jse_emit
   import jse_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  burst_type       burst,
   output emit_status_type status,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast
);

   logic                     busy_ff, busy_in;
   logic [CntW-1:0]          idx_ff, idx_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [MaxBytes-1:0][7:0] buf_ff, buf_in;
   logic                     take;
   logic                     last_take;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = buf_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == cnt_ff - CntW'(1));
   assign take       = busy_ff && rsp_tready;
   assign last_take  = take && rsp_tlast;

   assign status.busy     = busy_ff;
   assign status.can_load = !busy_ff || last_take;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      buf_in  = buf_ff;
      if (load) begin
         busy_in = (burst.count != '0);
         idx_in  = '0;
         cnt_in  = burst.count;
         buf_in  = burst.data;
      end else if (last_take) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
      end
      buf_ff <= buf_in;
   end

endmodule

// ===== tb/sv/tb_json_string_escape_utf8_unit.sv =====
// Testbench for json_string_escape_utf8_unit: UTF-16 code units in, escaped UTF-8 bytes out.
// Depends on jse_pkg and the block's RTL; it predicts every byte and checks it in order.
// Stimulus is a directed set of corner units followed by random strings with random idling.
module tb_json_string_escape_utf8_unit;
   import jse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Surrogate ranges of UTF-16
   localparam logic [15:0] HighFirst = 16'hd800;
   localparam logic [15:0] HighLast  = 16'hdbff;
   localparam logic [15:0] LowFirst  = 16'hdc00;
   localparam logic [15:0] LowLast   = 16'hdfff;

   localparam octet_type CharLowA = 8'h61;   // first hex letter, lowercase

   localparam int unsigned DirectedUnits = 26;
   localparam int unsigned RandomUnits   = 183;
   localparam int unsigned LongHoldAt    = 150;   // byte count that starts the long hold-off
   localparam int unsigned LongHoldLen   = 250;   // cycles of that hold-off

   // one code unit waiting to be sent
   typedef struct {
      logic [15:0] unit;
      logic        last;
      int unsigned gap;     // idle cycles before this unit is offered
      bit          drain;   // offer only once every predicted byte has arrived
   } code_unit_type;

   // one predicted output byte
   typedef struct {
      octet_type octet;
      logic      run_end;
   } escaped_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] code_unit
   logic        req_tlast = 1'b0;  // last_unit
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] out_byte
   logic        rsp_tlast;         // run_end

   code_unit_type    pending_units[$];
   escaped_byte_type escaped_bytes_q[$];
   octet_type        burst_bytes[$];    // bytes of the unit being predicted

   // predictor state: a high surrogate waiting for its partner
   bit          surrogate_held = 1'b0;
   logic [15:0] held_surrogate = '0;

   int unsigned units_queued   = 0;
   int unsigned units_accepted = 0;
   int unsigned bytes_seen     = 0;
   int unsigned error_count    = 0;
   int unsigned gap_left       = 0;
   int unsigned rsp_wait       = 0;
   code_unit_type    next_unit;
   escaped_byte_type want;

   json_string_escape_utf8_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   function automatic octet_type hex_char(input logic [3:0] nibble);
      return (nibble < 4'd10) ? CharZero + nibble : CharLowA + (nibble - 4'd10);
   endfunction

   // \uXXXX with lowercase digits
   function automatic void add_u_escape(input logic [15:0] u);
      burst_bytes.push_back(CharBslash);
      burst_bytes.push_back(CharU);
      burst_bytes.push_back(hex_char(u[15:12]));
      burst_bytes.push_back(hex_char(u[11:8]));
      burst_bytes.push_back(hex_char(u[7:4]));
      burst_bytes.push_back(hex_char(u[3:0]));
   endfunction

   // a unit taken on its own, with no surrogate waiting ahead of it
   function automatic void encode_single(input logic [15:0] u, input logic last);
      if (u < 16'h0080) begin
         if (u < 16'h0020 || u[7:0] == CharQuote || u[7:0] == CharBslash) begin
            burst_bytes.push_back(CharBslash);
            case (u[7:0])
               CharQuote:  burst_bytes.push_back(CharQuote);
               CharBslash: burst_bytes.push_back(CharBslash);
               CtlBs:      burst_bytes.push_back(CharB);
               CtlFf:      burst_bytes.push_back(CharF);
               CtlLf:      burst_bytes.push_back(CharN);
               CtlCr:      burst_bytes.push_back(CharR);
               CtlHt:      burst_bytes.push_back(CharT);
               default: begin
                  burst_bytes.push_back(CharU);
                  burst_bytes.push_back(CharZero);
                  burst_bytes.push_back(CharZero);
                  burst_bytes.push_back(hex_char(u[7:4]));
                  burst_bytes.push_back(hex_char(u[3:0]));
               end
            endcase
         end else begin
            burst_bytes.push_back(u[7:0]);
         end
      end else if (u < 16'h0800) begin
         burst_bytes.push_back({3'b110, u[10:6]});
         burst_bytes.push_back({2'b10, u[5:0]});
      end else if (u < HighFirst || u > LowLast) begin
         burst_bytes.push_back({4'b1110, u[15:12]});
         burst_bytes.push_back({2'b10, u[11:6]});
         burst_bytes.push_back({2'b10, u[5:0]});
      end else if (u <= HighLast) begin
         // high surrogate: held unless the string ends here
         if (last) begin
            add_u_escape(u);
         end else begin
            surrogate_held = 1'b1;
            held_surrogate = u;
         end
      end else begin
         add_u_escape(u);   // lone low surrogate
      end
   endfunction

   // work out the bytes of one accepted unit and queue them
   function automatic void escape_code_unit(input logic [15:0] u, input logic last);
      logic [20:0] code_point;
      logic [15:0] high;
      burst_bytes.delete();
      if (surrogate_held) begin
         high = held_surrogate;
         surrogate_held = 1'b0;
         held_surrogate = '0;
         if (u >= LowFirst && u <= LowLast) begin
            code_point = 21'h10000 + {1'b0, high[9:0], u[9:0]};
            burst_bytes.push_back({5'b11110, code_point[20:18]});
            burst_bytes.push_back({2'b10, code_point[17:12]});
            burst_bytes.push_back({2'b10, code_point[11:6]});
            burst_bytes.push_back({2'b10, code_point[5:0]});
         end else begin
            add_u_escape(high);
            encode_single(u, last);
         end
      end else begin
         encode_single(u, last);
      end
      foreach (burst_bytes[i])
         escaped_bytes_q.push_back('{burst_bytes[i], i == burst_bytes.size() - 1});
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   // idle cycles for one transaction; none at all inside the quiet window
   function automatic int unsigned draw_wait(input int unsigned idx, input int unsigned quiet_lo,
                                             input int unsigned quiet_hi);
      if (idx >= quiet_lo && idx < quiet_hi)
         return 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
   endfunction

   function automatic void add_unit(input logic [15:0] u, input logic last, input bit drain);
      pending_units.push_back('{u, last, draw_wait(units_queued, 80, 130), drain});
      units_queued++;
   endfunction

   initial begin
      int unsigned pick;
      logic [15:0] u;
      logic        last;
      bit          drain;

      // directed: control codes, short escapes, ASCII and UTF-8 boundaries
      add_unit(16'h0000, 1'b0, 1'b0);
      add_unit(16'h001f, 1'b0, 1'b0);
      add_unit({8'h00, CtlBs}, 1'b0, 1'b0);
      add_unit({8'h00, CtlFf}, 1'b0, 1'b0);
      add_unit({8'h00, CtlLf}, 1'b0, 1'b0);
      add_unit({8'h00, CtlCr}, 1'b0, 1'b0);
      add_unit({8'h00, CtlHt}, 1'b0, 1'b0);
      add_unit({8'h00, CharQuote}, 1'b0, 1'b0);
      add_unit({8'h00, CharBslash}, 1'b0, 1'b0);
      add_unit(16'h0020, 1'b0, 1'b0);
      add_unit(16'h007f, 1'b1, 1'b0);
      add_unit(16'h0080, 1'b0, 1'b0);
      add_unit(16'h07ff, 1'b0, 1'b0);
      add_unit(16'h0800, 1'b0, 1'b0);
      add_unit(16'hffff, 1'b1, 1'b0);
      // surrogate pairs at both ends of the range
      add_unit(HighFirst, 1'b0, 1'b0);
      add_unit(LowFirst, 1'b0, 1'b0);
      add_unit(HighLast, 1'b0, 1'b0);
      add_unit(LowLast, 1'b1, 1'b0);
      // held high flushed by a control code: the 12-byte burst
      add_unit(HighFirst, 1'b0, 1'b0);
      add_unit(16'h0001, 1'b0, 1'b0);
      // lone low, then high on the last unit
      add_unit(LowFirst, 1'b0, 1'b0);
      add_unit(HighLast, 1'b1, 1'b0);
      // high flushed by another high, which a 3-byte last unit then flushes
      add_unit(HighFirst, 1'b0, 1'b0);
      add_unit(16'hd801, 1'b0, 1'b0);
      add_unit(16'he000, 1'b1, 1'b0);

      // random strings, mostly well-formed text with some broken surrogates mixed in;
      // the first random unit waits until the directed bytes have all come back
      drain = 1'b1;
      while (units_queued < DirectedUnits + RandomUnits) begin
         pick = $urandom_range(0, 99);
         last = ($urandom_range(0, 7) == 0);
         if (pick < 35) begin
            u = $urandom_range(16'h0020, 16'h007e);
         end else if (pick < 45) begin
            u = $urandom_range(0, 33);
            if (u == 16'd32)
               u = {8'h00, CharQuote};
            else if (u == 16'd33)
               u = {8'h00, CharBslash};
         end else if (pick < 57) begin
            u = $urandom_range(16'h0080, 16'h07ff);
         end else if (pick < 69) begin
            // skip the surrogate block
            u = $urandom_range(16'h0800, 16'hf7ff);
            if (u >= HighFirst)
               u = u + 16'h0800;
         end else if (pick < 84) begin
            add_unit($urandom_range(HighFirst, HighLast), 1'b0, drain);
            drain = 1'b0;
            u = $urandom_range(LowFirst, LowLast);
         end else if (pick < 90) begin
            u = $urandom_range(HighFirst, HighLast);
         end else if (pick < 95) begin
            u = $urandom_range(LowFirst, LowLast);
         end else begin
            u = $urandom_range(0, 16'hffff);
         end
         add_unit(u, last, drain);
         drain = ($urandom_range(0, 39) == 0);
      end
      // close the string so nothing is left held
      add_unit(16'h0041, 1'b1, 1'b0);

      // every unit taken and every predicted byte seen, then a short tail for strays
      do
         @(posedge clock);
      while (units_accepted < units_queued || escaped_bytes_q.size() != 0);
      repeat (30) @(posedge clock);
      if (escaped_bytes_q.size() != 0) begin
         $display("%0t: %0d predicted bytes never arrived", $time, escaped_bytes_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d of %0d units accepted", $time, units_accepted, units_queued);
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Driver: offers queued units; predicts a unit's bytes on the edge it is accepted
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            escape_code_unit(req_tdata, req_tlast);
            units_accepted++;
         end
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_units.size() == 0 ||
                      (pending_units[0].drain && escaped_bytes_q.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            next_unit = pending_units.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_unit.unit;
            req_tlast  <= next_unit.last;
            gap_left = (pending_units.size() != 0) ? pending_units[0].gap : 0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: random stalls per byte, no stalls in a quiet window, and one long hold-off
   // while the sender keeps offering, so the block backs up into its input
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            bytes_seen++;
            rsp_wait = (bytes_seen == LongHoldAt) ? LongHoldLen : draw_wait(bytes_seen, 300, 480);
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: each byte transaction against the oldest prediction
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (escaped_bytes_q.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = escaped_bytes_q.pop_front();
            if (rsp_tdata !== want.octet) begin
               $display("%0t: out_byte mismatch, expected %h, actual %h",
                        $time, want.octet, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.run_end) begin
               $display("%0t: run_end mismatch, expected %b, actual %b",
                        $time, want.run_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

endmodule
